// ===== rtl/ufmt_pkg.sv =====
`default_nettype none
package ufmt_pkg;

  localparam int DEFAULT_MAX_FIELD_WIDTH = 64;
  localparam int VALUE_W = 32;
  localparam int WIDTH_W = 7;
  localparam int PREC_W = 8;
  localparam int CHAR_W = 8;
  localparam int NUM_DIGITS = 10;
  localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);
  localparam int SHIFT_CNT_W = $clog2(VALUE_W);

  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;

  typedef struct packed {
    logic load;
    logic shift;
    logic prep;
    logic emit;
  } ufmt_cmd_t;

  typedef struct packed {
    logic shift_last;
    logic empty;
    logic out_free;
    logic emit_last;
  } ufmt_stat_t;

endpackage
`default_nettype wire

// ===== rtl/ufmt_if.sv =====
`default_nettype none
interface ufmt_num_if;
  import ufmt_pkg::*;

  logic valid;
  logic ready;
  logic [VALUE_W-1:0] value;
  logic [WIDTH_W-1:0] field_width;
  logic signed [PREC_W-1:0] digit_precision;
  logic zero_pad;
  logic left_align;

  modport source (
    output valid, value, field_width, digit_precision, zero_pad, left_align,
    input ready
  );
  modport sink (
    input valid, value, field_width, digit_precision, zero_pad, left_align,
    output ready
  );
endinterface

interface ufmt_text_if;
  import ufmt_pkg::*;

  logic valid;
  logic ready;
  logic [CHAR_W-1:0] text_char;
  logic last_char;

  modport source (output valid, text_char, last_char, input ready);
  modport sink (input valid, text_char, last_char, output ready);
endinterface
`default_nettype wire

// ===== rtl/unsigned_decimal_field_formatter_core.sv =====
`default_nettype none
// Formats one 32-bit unsigned number as printf %u text.
// The number channel carries the value, the field width, the precision
// (negative means not given), the zero flag and the left-align flag.
// The text channel returns one ASCII character per transaction, and the
// final character of a field carries last_char.
// A number transaction is taken only while the block is idle. The value is
// converted to BCD by a shift-and-add-3 loop, one bit per cycle, followed
// by the PREP state, which sizes the field. The characters then leave at
// one per cycle from the output register while the receiver takes them;
// a field holds at most MAX_FIELD_WIDTH characters.
// A field of zero characters (zero value, zero precision, zero width)
// produces no transaction at all.
// When the receiver stalls, the output register holds its character and
// the character sequencer waits; no character is lost or repeated.
// Reset returns the block to idle and empties the output register.
module unsigned_decimal_field_formatter_core #(
  parameter int MAX_FIELD_WIDTH = ufmt_pkg::DEFAULT_MAX_FIELD_WIDTH
) (
  input wire logic   clk,
  input wire logic   rst,
  ufmt_num_if.sink   number,
  ufmt_text_if.source text
);
  import ufmt_pkg::*;

  ufmt_cmd_t cmd;
  ufmt_stat_t stat;
  logic in_ready;

  ufmt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (number.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ufmt_datapath #(
    .MAX_FIELD_WIDTH (MAX_FIELD_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .value           (number.value),
    .field_width     (number.field_width),
    .digit_precision (number.digit_precision),
    .zero_pad        (number.zero_pad),
    .left_align      (number.left_align),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (text.valid),
    .out_ready       (text.ready),
    .text_char       (text.text_char),
    .last_char       (text.last_char)
  );

  assign number.ready = in_ready;

  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (rst)
    number.valid && number.ready |=> !number.ready
  ) else $error("number channel ready right after a transaction");

  a_char_set: assert property (
    @(posedge clk) disable iff (rst)
    text.valid |-> (text.text_char == CHAR_SPACE) ||
                   ((text.text_char >= CHAR_ZERO) &&
                    (text.text_char <= CHAR_ZERO + 8'd9))
  ) else $error("text character is neither a space nor a digit");

  a_idle_after_reset: assert property (
    @(posedge clk) rst |=> number.ready && !text.valid
  ) else $error("block not idle after reset");
endmodule
`default_nettype wire

// ===== rtl/ufmt_ctrl.sv =====
`default_nettype none
module ufmt_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ufmt_pkg::ufmt_stat_t stat,
  output ufmt_pkg::ufmt_cmd_t      cmd
);
  import ufmt_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    CONVERT,
    PREP,
    EMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = CONVERT;
        end
      end
      CONVERT: begin
        cmd.shift = 1'b1;
        if (stat.shift_last) begin
          state_next = PREP;
        end
      end
      PREP: begin
        cmd.prep = 1'b1;
        state_next = EMIT;
      end
      EMIT: begin
        if (stat.empty) begin
          state_next = IDLE;
        end else if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.emit_last) begin
            state_next = IDLE;
          end
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  assign in_ready = (state == IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/ufmt_datapath.sv =====
`default_nettype none
module ufmt_datapath #(
  parameter int MAX_FIELD_WIDTH = ufmt_pkg::DEFAULT_MAX_FIELD_WIDTH
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic [ufmt_pkg::VALUE_W-1:0]         value,
  input  wire logic [ufmt_pkg::WIDTH_W-1:0]         field_width,
  input  wire logic signed [ufmt_pkg::PREC_W-1:0]   digit_precision,
  input  wire logic                                 zero_pad,
  input  wire logic                                 left_align,
  input  wire ufmt_pkg::ufmt_cmd_t                  cmd,
  output ufmt_pkg::ufmt_stat_t                      stat,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [ufmt_pkg::CHAR_W-1:0]               text_char,
  output logic                                      last_char
);
  import ufmt_pkg::*;

  localparam int CW = $clog2(MAX_FIELD_WIDTH + 1);
  localparam logic [WIDTH_W-1:0] MAX_W = WIDTH_W'(MAX_FIELD_WIDTH);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_FIELD_WIDTH);

  logic [VALUE_W-1:0] shreg;
  logic [3:0] bcd [NUM_DIGITS];
  logic [3:0] bcd_next [NUM_DIGITS];
  logic [3:0] adj [NUM_DIGITS];
  logic [SHIFT_CNT_W-1:0] shift_cnt;
  logic [CW-1:0] width_sat;
  logic [CW-1:0] prec_eff;
  logic given_eff;
  logic left;
  logic [DIGIT_IDX_W-1:0] len;
  logic [CW-1:0] ndig;
  logic [CW-1:0] spaces;
  logic [CW-1:0] total;
  logic [CW-1:0] pos;

  logic [CW-1:0] width_in;
  logic [CW-1:0] prec_in;
  logic prec_given;
  logic [DIGIT_IDX_W-1:0] len_next;
  logic [CW-1:0] len_c;
  logic [CW-1:0] ndig_next;
  logic [CW-1:0] total_next;
  logic [CW-1:0] lead;
  logic signed [CW:0] d;
  logic [CW-1:0] nzero;
  logic [CW-1:0] didx_full;
  logic [DIGIT_IDX_W-1:0] didx;
  logic [CHAR_W-1:0] char_next;

  always_comb begin
    width_in = (field_width > MAX_W) ? MAX_C : CW'(field_width);
    prec_given = ~digit_precision[PREC_W-1];
    prec_in = (digit_precision[PREC_W-2:0] > MAX_W) ? MAX_C
                                                   : CW'(digit_precision[PREC_W-2:0]);
  end

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
    bcd_next[0] = {adj[0][2:0], shreg[VALUE_W-1]};
    for (int i = 1; i < NUM_DIGITS; i++) begin
      bcd_next[i] = {adj[i][2:0], adj[i-1][3]};
    end
  end

  always_comb begin
    len_next = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[i] != 4'd0) begin
        len_next = DIGIT_IDX_W'(i + 1);
      end
    end
    len_c = CW'(len_next);
    if (!given_eff) begin
      ndig_next = (len_next == '0) ? CW'(1) : len_c;
    end else begin
      ndig_next = (prec_eff > len_c) ? prec_eff : len_c;
    end
    total_next = (width_sat > ndig_next) ? width_sat : ndig_next;
  end

  always_comb begin
    lead = left ? '0 : spaces;
    d = $signed({1'b0, pos}) - $signed({1'b0, lead});
    nzero = ndig - CW'(len);
    didx_full = ndig - CW'(1) - d[CW-1:0];
    didx = didx_full[DIGIT_IDX_W-1:0];
    if (d[CW] || (d[CW-1:0] >= ndig)) begin
      char_next = CHAR_SPACE;
    end else if (d[CW-1:0] < nzero) begin
      char_next = CHAR_ZERO;
    end else begin
      char_next = CHAR_ZERO + CHAR_W'(bcd[didx]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      shreg <= value;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        bcd[i] <= 4'd0;
      end
      shift_cnt <= '0;
      width_sat <= width_in;
      left <= left_align;
      given_eff <= prec_given | (zero_pad & ~left_align);
      prec_eff <= prec_given ? prec_in : width_in;
    end
    if (cmd.shift) begin
      shreg <= {shreg[VALUE_W-2:0], 1'b0};
      bcd <= bcd_next;
      shift_cnt <= shift_cnt + SHIFT_CNT_W'(1);
    end
    if (cmd.prep) begin
      len <= len_next;
      ndig <= ndig_next;
      total <= total_next;
      spaces <= total_next - ndig_next;
      pos <= '0;
    end
    if (cmd.emit) begin
      pos <= pos + CW'(1);
      text_char <= char_next;
      last_char <= stat.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    stat.shift_last = (shift_cnt == SHIFT_CNT_W'(VALUE_W - 1));
    stat.empty = (total == '0);
    stat.out_free = ~out_valid | out_ready;
    stat.emit_last = (pos == total - CW'(1));
  end
endmodule
`default_nettype wire
